/* rtl/positional_insert_list_macros.svh */
// Assertion macros for the positional insert list RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef POSITIONAL_INSERT_LIST_MACROS_SVH
`define POSITIONAL_INSERT_LIST_MACROS_SVH
`ifndef SYNTH
`define PIL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pil assertion failed");
`define PIL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pil assertion failed");
`define PIL_ASSERT_LAT2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("pil assertion failed");
`else
`define PIL_ASSERT_IMP(label, clk, rst, ante, cons)
`define PIL_ASSERT_NXT(label, clk, rst, ante, cons)
`define PIL_ASSERT_LAT2(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/pil_pkg.sv */
// Shared sizes, codes and types for the positional insert list.
// No dependencies; imported by every module of the block.
`default_nettype none
package pil_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_INSERT     = 3'd4,
      MODE_PEEK       = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Cell update command from the control to the cell array
   typedef struct packed {
      logic             ins_en;
      logic             pop_en;
      logic [CNT_W-1:0] ins_pos;
   } cell_op_type;

endpackage
`default_nettype wire

/* rtl/pil_ctrl.sv */
// Command decode, status and element count for the positional insert list.
// Depends on pil_pkg.
`default_nettype none
module pil_ctrl
   import pil_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  wire logic [2:0]       item_mode,
   input  wire logic [POS_W-1:0] item_position,
   output status_type            status,
   output cell_op_type           cell_op,
   output logic [CNT_W-1:0]      cnt_in
);

   logic [CNT_W-1:0] cnt_ff;
   logic             full;
   logic             empty;
   logic             pos_bad;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pos_bad = (CMP_W'(item_position) > CMP_W'(cnt_ff));

   // Decode the word into a status and a cell command
   always_comb begin
      status          = ST_OK;
      cell_op.ins_en  = 1'b0;
      cell_op.pop_en  = 1'b0;
      cell_op.ins_pos = '0;
      cnt_in          = cnt_ff;
      case (mode_type'(item_mode))
         MODE_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               cell_op.ins_en  = item_valid;
               cell_op.ins_pos = '0;
               cnt_in          = cnt_ff + CNT_W'(1);
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               cell_op.ins_en  = item_valid;
               cell_op.ins_pos = cnt_ff;
               cnt_in          = cnt_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               cell_op.pop_en = item_valid;
               cnt_in         = cnt_ff - CNT_W'(1);
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         MODE_INSERT: begin
            if (pos_bad) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cell_op.ins_en  = item_valid;
               cell_op.ins_pos = CNT_W'(item_position);
               cnt_in          = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            // peek and the unused codes only look
            if (empty) begin
               status = ST_EMPTY;
            end
         end
      endcase
   end

   // Advance the count only when a word is in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (item_valid) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/pil_cell_array.sv */
// Cell storage of the positional insert list: cells above the insert position shift
// by one place in parallel on insert, every cell on front pop. Depends on pil_pkg.
`default_nettype none
module pil_cell_array
   import pil_pkg::*;
(
   input  wire logic        clock,
   input  wire cell_op_type cell_op,
   input  wire word_type    item_value,
   input  wire logic [CNT_W-1:0] cnt_in,
   output word_type         front_value,
   output word_type         back_value
);

   word_type         cells_ff [DEPTH];
   word_type         cells_in [DEPTH];
   logic [IDX_W-1:0] back_idx;

   // Pick each cell's next value from itself or a neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         cells_in[i] = cells_ff[i];
         if (cell_op.ins_en) begin
            if (CNT_W'(i) == cell_op.ins_pos) begin
               cells_in[i] = item_value;
            end else if (CNT_W'(i) > cell_op.ins_pos) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cell_op.pop_en) begin
            cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   // Read front and back as they stand after the word
   assign back_idx    = IDX_W'(cnt_in - CNT_W'(1));
   assign front_value = cells_in[0];
   assign back_value  = cells_in[back_idx];

endmodule
`default_nettype wire

/* rtl/positional_insert_list.sv */
// Top level of the positional insert list: input register, control,
// cell array and result register. Depends on pil_pkg, pil_ctrl, pil_cell_array.
//
//   port group  direction  handshake
//   req_*       in         start high and busy low at a rising edge
//   rsp_*       out        rsp_strobe high for one cycle, no back pressure
//
// One word is taken every cycle while busy is low; its result passes the input
// register, then the parallel shift of the cells, then the result register.
// busy is reset delayed by a register: it is still high in the cycle after reset falls; it is low otherwise.
// Cell contents are not cleared by reset; the element count and the valid and strobe flags are.
// Results cannot be stalled, so nothing on the result side holds off input.
`default_nettype none
`include "positional_insert_list_macros.svh"
module positional_insert_list
   import pil_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [2:0]          req_mode,
   input  wire logic [POS_W-1:0]    req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_front_value,
   output logic signed [DATA_W-1:0] rsp_back_value,
   output logic [CNT_W-1:0]         rsp_element_count,
   output logic                     rsp_not_empty
);

   logic             busy_ff;
   logic             item_valid_ff;
   logic             item_valid_in;
   logic [2:0]       item_mode_ff;
   logic [POS_W-1:0] item_position_ff;
   word_type         item_value_ff;

   status_type       status;
   cell_op_type      cell_op;
   logic [CNT_W-1:0] cnt_in;
   word_type         front_value;
   word_type         back_value;
   logic             not_empty;

   logic             rsp_strobe_ff;
   logic [1:0]       rsp_status_ff;
   word_type         rsp_front_ff;
   word_type         rsp_back_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_not_empty_ff;

   assign busy          = busy_ff;
   assign item_valid_in = start && !busy_ff;

   // Hold off input during reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_in) begin
         item_mode_ff     <= req_mode;
         item_position_ff <= req_position;
         item_value_ff    <= req_value;
      end
   end

   pil_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid_ff),
      .item_mode     (item_mode_ff),
      .item_position (item_position_ff),
      .status        (status),
      .cell_op       (cell_op),
      .cnt_in        (cnt_in)
   );

   pil_cell_array u_cells (
      .clock       (clock),
      .cell_op     (cell_op),
      .item_value  (item_value_ff),
      .cnt_in      (cnt_in),
      .front_value (front_value),
      .back_value  (back_value)
   );

   assign not_empty = (cnt_in != '0);

   // Register the result word; zero the ends when the list is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_ff) begin
         rsp_status_ff    <= status;
         rsp_front_ff     <= not_empty ? front_value : '0;
         rsp_back_ff      <= not_empty ? back_value : '0;
         rsp_count_ff     <= cnt_in;
         rsp_not_empty_ff <= not_empty;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_back_value    = rsp_back_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_not_empty     = rsp_not_empty_ff;

   // Checks on count, latency and result consistency
   `PIL_ASSERT_IMP(a_cnt_bound, clock, reset, item_valid_ff, cnt_in <= CNT_W'(DEPTH))
   `PIL_ASSERT_LAT2(a_rsp_latency, clock, reset, start && !busy, rsp_strobe)
   `PIL_ASSERT_NXT(a_strobe_cause, clock, reset, !item_valid_ff, !rsp_strobe)
   `PIL_ASSERT_IMP(a_flag_match, clock, reset, rsp_strobe, rsp_not_empty == (rsp_element_count != '0))
   `PIL_ASSERT_IMP(a_full_count, clock, reset, rsp_strobe && (rsp_status == ST_FULL), rsp_element_count == CNT_W'(DEPTH))

endmodule
`default_nettype wire
